[sv/act_pkg.sv]
// Shared types, codes and box arithmetic for the AABB collision table.
package act_pkg;

  localparam int MAX_BOXES_DEF = 32;

  localparam int COORD_W = 16;
  localparam int SIZE_W  = 15;
  localparam int WORLD_W = 15;
  localparam int SUM_W   = 18;

  typedef enum logic [1:0] {
    F_APPEND = 2'd0,
    F_MOVE   = 2'd1,
    F_PASS   = 2'd2,
    F_CLEAR  = 2'd3
  } func_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_FULL     = 2'd1,
    ST_BAD_SLOT = 2'd2
  } status_t;

  localparam logic [1:0] REG_WORLD_WIDTH  = 2'd0;
  localparam logic [1:0] REG_WORLD_HEIGHT = 2'd1;

  typedef enum logic [2:0] {
    C_NOP    = 3'd0,
    C_APPEND = 3'd1,
    C_MOVE   = 3'd2,
    C_START  = 3'd3,
    C_STEP   = 3'd4,
    C_FINISH = 3'd5
  } cell_op_t;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic [SIZE_W-1:0]         w;
    logic [SIZE_W-1:0]         h;
  } box_geom_t;

  // Box packet rotating through the ring during a pass.
  typedef struct packed {
    box_geom_t geom;
    logic      live;
  } trav_t;

  // Broadcast from the sequencer to every cell.
  typedef struct packed {
    cell_op_t           op;
    box_geom_t          geom;
    logic               enabled;
    logic [WORLD_W-1:0] world_w;
    logic [WORLD_W-1:0] world_h;
  } cell_ctrl_t;

  typedef struct packed {
    logic oob;
    logic ov;
  } cell_flags_t;

  function automatic logic signed [SUM_W-1:0] sx(input logic [COORD_W-1:0] v);
    return SUM_W'($signed(v));
  endfunction

  function automatic logic signed [SUM_W-1:0] zx(input logic [SIZE_W-1:0] v);
    return $signed({{(SUM_W-SIZE_W){1'b0}}, v});
  endfunction

  // Strict overlap on both axes; touching edges do not count.
  function automatic logic box_hits(input box_geom_t a, input box_geom_t b);
    return (sx(a.x) + zx(a.w) > sx(b.x)) && (sx(a.x) < sx(b.x) + zx(b.w)) &&
           (sx(a.y) + zx(a.h) > sx(b.y)) && (sx(a.y) < sx(b.y) + zx(b.h));
  endfunction

  function automatic logic box_outside(input box_geom_t g,
                                       input logic [WORLD_W-1:0] ww,
                                       input logic [WORLD_W-1:0] wh);
    return (sx(g.x) + zx(g.w) > zx(ww)) || g.x[COORD_W-1] ||
           (sx(g.y) + zx(g.h) > zx(wh)) || g.y[COORD_W-1];
  endfunction

endpackage

[sv/act_req_if.sv]
// Request channel: one table operation per request.
interface act_req_if;
  logic               valid;
  logic               ready;
  logic [1:0]         func;
  logic [4:0]         slot;
  logic signed [15:0] pos_x;
  logic signed [15:0] pos_y;
  logic [14:0]        size_w;
  logic [14:0]        size_h;
  logic               enabled;

  modport source (output valid, func, slot, pos_x, pos_y, size_w, size_h, enabled,
                  input ready);
  modport sink   (input valid, func, slot, pos_x, pos_y, size_w, size_h, enabled,
                  output ready);
endinterface

[sv/act_rsp_if.sv]
// Result channel: one box report per table request; a collision pass reports each stored box.
interface act_rsp_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [4:0] box_id;
  logic       out_of_bounds;
  logic       overlapping;
  logic [4:0] overlap_partner;
  logic       last;

  modport source (output valid, status, box_id, out_of_bounds, overlapping,
                  overlap_partner, last, input ready);
  modport sink   (input valid, status, box_id, out_of_bounds, overlapping,
                  overlap_partner, last, output ready);
endinterface

[sv/aabb_collision_table_core.sv]
// AABB collision table: append/move/clear are handled in idle, result registered next cycle.
// Collision pass: load, ring rotation and commit steps, then one result per cycle
// for each stored box while the output is free (count results).
// Pass length is set by the packet ring: every box travels past every other cell once.
// Reset: table empty, flags zero, world bounds 32767; box geometry undefined until written.
module aabb_collision_table_core #(
  parameter int MAX_BOXES = act_pkg::MAX_BOXES_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [14:0] cfg_data,
  act_req_if.sink     req,
  act_rsp_if.source   rsp
);
  import act_pkg::*;

  localparam int IDW = (MAX_BOXES > 1) ? $clog2(MAX_BOXES) : 1;
  localparam int CW  = $clog2(MAX_BOXES + 1);
  localparam int EW  = IDW + 1;
  localparam logic [IDW-1:0] LAST_STEP = IDW'(MAX_BOXES - 1);
  localparam logic [CW-1:0]  FULL_CNT  = CW'(MAX_BOXES);

  // Sequencer: idle handles single requests; a pass rotates, commits, then streams.
  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_PASS = 4'b0010,
    S_FIN  = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t         state;
  logic [IDW-1:0] step_cnt;
  logic [IDW-1:0] emit_idx;
  logic [CW-1:0]  count;

  logic [WORLD_W-1:0] world_w;
  logic [WORLD_W-1:0] world_h;

  // output register
  logic       out_valid;
  status_t    out_status;
  logic [4:0] out_id;
  logic       out_oob;
  logic       out_ov;
  logic [4:0] out_partner;
  logic       out_last;

  logic       out_free;
  logic       accept;
  func_t      func;
  logic       full;
  logic       slot_ok;
  logic       emit_last;

  cell_ctrl_t     ctrl;
  logic [IDW-1:0] sel;
  logic [IDW-1:0] rd_idx;

  trav_t          trav     [MAX_BOXES];
  logic [IDW-1:0] trav_id  [MAX_BOXES];
  cell_flags_t    flags    [MAX_BOXES];
  logic [IDW-1:0] partner  [MAX_BOXES];

  assign func      = func_t'(req.func);
  assign out_free  = !out_valid || rsp.ready;
  assign req.ready = (state == S_IDLE) && out_free;
  assign accept    = req.valid && req.ready;
  assign full      = count == FULL_CNT;
  assign slot_ok   = {3'b000, req.slot} < 8'(count);
  assign emit_last = EW'(emit_idx) + EW'(1) == EW'(count);

  // One shared read port into the cell flags: stream index in a pass, else the slot.
  assign rd_idx = (state == S_EMIT) ? emit_idx : IDW'(req.slot);

  always_comb begin
    ctrl.op      = C_NOP;
    ctrl.geom.x  = req.pos_x;
    ctrl.geom.y  = req.pos_y;
    ctrl.geom.w  = req.size_w;
    ctrl.geom.h  = req.size_h;
    ctrl.enabled = req.enabled;
    ctrl.world_w = world_w;
    ctrl.world_h = world_h;
    sel          = (func == F_APPEND) ? IDW'(count) : IDW'(req.slot);
    priority if (accept) begin
      unique case (func)
        F_APPEND: if (!full)          ctrl.op = C_APPEND;
        F_MOVE:   if (slot_ok)        ctrl.op = C_MOVE;
        F_PASS:   if (count != '0)    ctrl.op = C_START;
        default:  ctrl.op = C_NOP;
      endcase
    end else if (state == S_PASS) begin
      ctrl.op = C_STEP;
    end else if (state == S_FIN) begin
      ctrl.op = C_FINISH;
    end else begin
      ctrl.op = C_NOP;
    end
  end

  // Ring of cells: each cell takes its packet from the cell below it.
  for (genvar i = 0; i < MAX_BOXES; i++) begin : g_cell
    localparam int PREV = (i == 0) ? MAX_BOXES - 1 : i - 1;
    act_cell #(
      .IDW (IDW),
      .CW  (CW),
      .ID  (i)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .ctrl        (ctrl),
      .sel         (sel),
      .count       (count),
      .trav_in     (trav[PREV]),
      .trav_in_id  (trav_id[PREV]),
      .trav_out    (trav[i]),
      .trav_out_id (trav_id[i]),
      .flags       (flags[i]),
      .partner     (partner[i])
    );
  end

  // configuration
  always_ff @(posedge clk) begin
    if (rst) begin
      world_w <= '1;
      world_h <= '1;
    end else if (cfg_we) begin
      if (cfg_index == REG_WORLD_WIDTH)  world_w <= cfg_data;
      if (cfg_index == REG_WORLD_HEIGHT) world_h <= cfg_data;
    end
  end

  // sequencer and box count
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      count    <= '0;
      step_cnt <= '0;
      emit_idx <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (func)
              F_APPEND: if (!full) count <= count + CW'(1);
              F_CLEAR:  count <= '0;
              F_PASS: begin
                if (count != '0) begin
                  state    <= S_PASS;
                  step_cnt <= IDW'(1);
                end
              end
              default: ;
            endcase
          end
        end
        S_PASS: begin
          if (step_cnt == LAST_STEP) state <= S_FIN;
          else step_cnt <= step_cnt + IDW'(1);
        end
        S_FIN: begin
          state    <= S_EMIT;
          emit_idx <= '0;
        end
        S_EMIT: begin
          if (out_free) begin
            if (emit_last) state <= S_IDLE;
            else emit_idx <= emit_idx + IDW'(1);
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if ((accept && func != F_PASS) || (state == S_EMIT && out_free)) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  // output register payload
  always_ff @(posedge clk) begin
    if (state == S_EMIT && out_free) begin
      out_status  <= ST_OK;
      out_id      <= 5'(emit_idx);
      out_oob     <= flags[rd_idx].oob;
      out_ov      <= flags[rd_idx].ov;
      out_partner <= 5'(partner[rd_idx]);
      out_last    <= emit_last;
    end else if (accept) begin
      out_status  <= ST_OK;
      out_id      <= '0;
      out_oob     <= 1'b0;
      out_ov      <= 1'b0;
      out_partner <= '0;
      out_last    <= 1'b1;
      unique case (func)
        F_APPEND: begin
          if (full) out_status <= ST_FULL;
          else out_id <= 5'(count);
        end
        F_MOVE: begin
          out_id <= req.slot;
          if (slot_ok) begin
            out_oob     <= flags[rd_idx].oob;
            out_ov      <= flags[rd_idx].ov;
            out_partner <= 5'(partner[rd_idx]);
          end else begin
            out_status <= ST_BAD_SLOT;
          end
        end
        default: ;
      endcase
    end
  end

  assign rsp.valid           = out_valid;
  assign rsp.status          = out_status;
  assign rsp.box_id          = out_id;
  assign rsp.out_of_bounds   = out_oob;
  assign rsp.overlapping     = out_ov;
  assign rsp.overlap_partner = out_partner;
  assign rsp.last            = out_last;

endmodule

[sv/act_cell.sv]
// One table entry: stores a box, its flags, and tests the rotating packet.
module act_cell #(
  parameter int IDW = 5,
  parameter int CW  = 6,
  parameter int ID  = 0
) (
  input  logic                clk,
  input  logic                rst,
  input  act_pkg::cell_ctrl_t ctrl,
  input  logic [IDW-1:0]      sel,
  input  logic [CW-1:0]       count,
  input  act_pkg::trav_t      trav_in,
  input  logic [IDW-1:0]      trav_in_id,
  output act_pkg::trav_t      trav_out,
  output logic [IDW-1:0]      trav_out_id,
  output act_pkg::cell_flags_t flags,
  output logic [IDW-1:0]      partner
);
  import act_pkg::*;

  localparam logic [IDW-1:0] MY_ID = IDW'(ID);
  localparam logic [CW-1:0]  MY_ID_C = CW'(ID);

  box_geom_t      geom;
  logic           en;
  trav_t          trav;
  logic [IDW-1:0] trav_id;
  logic           hit;
  logic [IDW-1:0] best;
  logic           in_use;
  logic           own_live;
  logic           sel_me;
  logic           pair_hit;

  assign in_use   = MY_ID_C < count;
  assign own_live = in_use && en;
  assign sel_me   = sel == MY_ID;
  assign pair_hit = own_live && trav_in.live && box_hits(geom, trav_in.geom);

  assign trav_out    = trav;
  assign trav_out_id = trav_id;

  // box storage, no reset
  always_ff @(posedge clk) begin
    if (ctrl.op == C_APPEND && sel_me) begin
      geom <= ctrl.geom;
      en   <= ctrl.enabled;
    end else if (ctrl.op == C_MOVE && sel_me) begin
      geom.x <= ctrl.geom.x;
      geom.y <= ctrl.geom.y;
      en     <= ctrl.enabled;
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.op == C_START) begin
      trav.geom <= geom;
      trav.live <= own_live;
      trav_id   <= MY_ID;
    end else if (ctrl.op == C_STEP) begin
      trav    <= trav_in;
      trav_id <= trav_in_id;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      flags   <= '0;
      partner <= '0;
      hit     <= 1'b0;
      best    <= '0;
    end else begin
      unique case (ctrl.op)
        C_APPEND: begin
          if (sel_me) begin
            flags   <= '0;
            partner <= '0;
          end
        end
        C_START: begin
          hit <= 1'b0;
          if (in_use) flags.oob <= box_outside(geom, ctrl.world_w, ctrl.world_h);
        end
        C_STEP: begin
          if (pair_hit) begin
            hit <= 1'b1;
            if (!hit || trav_in_id > best) best <= trav_in_id;
          end
        end
        C_FINISH: begin
          if (hit) begin
            flags.ov <= 1'b1;
            partner  <= best;
          end
        end
        default: ;
      endcase
    end
  end

endmodule
